/* hdl/fdm_pkg.sv */
// Package for the frequency and duty meter: payload structs, the front-to-back
// job word, divider request and response, and the range tables.
// Used by every module of the block; has no dependencies.
package fdm_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int HIST_DEPTH = 8;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
	localparam int HZ_W       = 32 + FRAC_BITS;
	localparam int DNUM_W     = 47;
	localparam int DIV_W      = 48;
	localparam int CNT_W      = $clog2(DIV_W + 1);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SIG   = 2'd1;
	localparam logic [1:0] ST_OVER     = 2'd2;
	localparam logic [1:0] ST_HW_FAIL  = 2'd3;

	localparam logic [2:0] RANGE_AUTO  = 3'd0;
	localparam logic [2:0] RANGE_RESET = 3'd3;
	localparam logic [2:0] NO_CAND     = 3'd7;

	localparam logic REG_SELECT  = 1'b0;
	localparam logic REG_STARTED = 1'b1;

	typedef struct packed {
		logic        capture_valid;
		logic [31:0] period_cnt;
		logic [31:0] high_cnt;
		logic [31:0] clock_hz;
	} capture_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [25:0] avg_hz;
		logic [14:0] avg_duty;
		logic [2:0]  active_range;
		logic        overrange;
		logic        range_changed;
		logic [7:0]  invalid_streak;
		logic [3:0]  history_level;
	} result_t;

	typedef struct packed {
		logic              invalid;
		logic [31:0]       period;
		logic [HZ_W-1:0]   hz_num;
		logic [DNUM_W-1:0] duty_num;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [31:0]      den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	// Decade tops and guard bands, already scaled by the fraction bits.
	function automatic logic [HZ_W-1:0] decade_top(input logic [2:0] r);
		logic [31:0] v;
		unique case (r)
			3'd1:    v = 32'd20;
			3'd2:    v = 32'd200;
			3'd3:    v = 32'd2000;
			3'd4:    v = 32'd20000;
			3'd5:    v = 32'd200000;
			default: v = 32'd0;
		endcase
		return {v, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic [HZ_W-1:0] guard_min(input logic [2:0] r);
		logic [31:0] v;
		unique case (r)
			3'd2:    v = 32'd18;
			3'd3:    v = 32'd180;
			3'd4:    v = 32'd1800;
			3'd5:    v = 32'd18000;
			default: v = 32'd0;
		endcase
		return {v, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic [HZ_W-1:0] guard_max(input logic [2:0] r);
		logic [31:0] v;
		unique case (r)
			3'd1:    v = 32'd22;
			3'd2:    v = 32'd220;
			3'd3:    v = 32'd2200;
			3'd4:    v = 32'd22000;
			3'd5:    v = 32'd220000;
			default: v = 32'd0;
		endcase
		return {v, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic [3:0] bad_capture_limit(input logic [2:0] r);
		logic [3:0] v;
		unique case (r)
			3'd1:    v = 4'd8;
			3'd2:    v = 4'd7;
			3'd3:    v = 4'd5;
			3'd4:    v = 4'd4;
			3'd5:    v = 4'd3;
			default: v = 4'd5;
		endcase
		return v;
	endfunction

endpackage

/* hdl/fdm_front.sv */
// Front end of the meter: checks each capture, forms the divider numerators and
// holds jobs in a two-entry queue for the back end. Depends on fdm_pkg.
module fdm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  fdm_pkg::capture_t capture,
	input  logic             take,
	output logic             avail,
	output fdm_pkg::job_t    head
);
	import fdm_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	job_t       job;
	logic [DNUM_W-1:0] high_x;
	logic       do_push;
	logic       do_take;

	// Duty numerator is high * 100 * 256 = high * 25600 = high * (2^14 + 2^13 + 2^10).
	assign high_x = DNUM_W'(capture.high_cnt);

	always_comb begin
		job.invalid  = !capture.capture_valid || (capture.period_cnt == 32'd0)
			|| (capture.clock_hz == 32'd0) || (capture.high_cnt > capture.period_cnt);
		job.period   = capture.period_cnt;
		job.hz_num   = {capture.clock_hz, {FRAC_BITS{1'b0}}};
		job.duty_num = (high_x << 14) + (high_x << 13) + (high_x << 10);
	end

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_take) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!do_push && do_take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* hdl/fdm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions of the
// back end. Depends on fdm_pkg.
module fdm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fdm_pkg::div_req_t req,
	output fdm_pkg::div_rsp_t rsp
);
	import fdm_pkg::*;

	logic [31:0]      den_q;
	logic [31:0]      rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= 32'd0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, den_q}) : shifted[31:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

/* hdl/fdm_back.sv */
// Back end of the meter: sequences the divisions, range tracking, history ring
// and averaging for one job at a time, and holds the result register.
// Depends on fdm_pkg; drives the shared fdm_div unit.
module fdm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [2:0]        cfg_data,
	input  logic              avail,
	input  fdm_pkg::job_t     head,
	output logic              take,
	output fdm_pkg::div_req_t div_req,
	input  fdm_pkg::div_rsp_t div_rsp,
	output logic              empty,
	input  logic              pop,
	output fdm_pkg::result_t  result
);
	import fdm_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DHZ    = 8'b0000_0010,
		S_DDUTY  = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_SUM    = 8'b0001_0000,
		S_AVGH   = 8'b0010_0000,
		S_AVGD   = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [HZ_W-1:0]   hz_q;
	logic [14:0]       duty_q;
	logic [25:0]       hist_hz_q   [HIST_DEPTH];
	logic [14:0]       hist_duty_q [HIST_DEPTH];
	logic [HIST_AW-1:0] wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        inv_cnt_q;
	logic [2:0]        range_q;
	logic [2:0]        cand_q;
	logic [1:0]        votes_q;
	logic              ovf_q;
	logic [2:0]        sel_q;
	logic              started_q;
	logic [HIST_AW-1:0] idx_q;
	logic [FILL_W-1:0] n_q;
	logic [FILL_W-1:0] left_q;
	logic [28:0]       sum_hz_q;
	logic [17:0]       sum_duty_q;
	logic [1:0]        status_q;
	logic              changed_q;
	logic [25:0]       avg_hz_q;
	logic [14:0]       avg_duty_q;
	logic              out_valid_q;
	result_t           out_q;

	// Invalid capture decision.
	logic [7:0]        inc_cnt;
	logic              hw_fail;
	logic              stale;
	logic [7:0]        eff_cnt;
	logic              use_hist;

	// Valid capture decision.
	logic [2:0]        target;
	logic [3:0]        range_up;
	logic [HZ_W+2:0]   hz_x5;
	logic              fast;
	logic [1:0]        next_votes;
	logic              do_switch;
	logic              in_band;
	logic              switching;
	logic              store;
	logic [FILL_W-1:0] new_fill;
	logic [FILL_W-1:0] window;
	logic [HIST_AW-1:0] prev_idx;
	logic              out_free;
	logic [2:0]        cfg_sel;

	always_comb begin
		inc_cnt  = (inv_cnt_q == 8'd255) ? inv_cnt_q : inv_cnt_q + 8'd1;
		hw_fail  = !started_q && (fill_q == '0);
		stale    = (range_q >= 3'd4) && (inc_cnt >= 8'd2);
		eff_cnt  = stale ? 8'd0 : inc_cnt;
		use_hist = !stale && (fill_q != '0) && (eff_cnt < 8'(bad_capture_limit(range_q)));
	end

	always_comb begin
		if (hz_q == '0) begin
			target = 3'd0;
		end else if (hz_q <= decade_top(3'd1)) begin
			target = 3'd1;
		end else if (hz_q <= decade_top(3'd2)) begin
			target = 3'd2;
		end else if (hz_q <= decade_top(3'd3)) begin
			target = 3'd3;
		end else if (hz_q <= decade_top(3'd4)) begin
			target = 3'd4;
		end else if (hz_q <= decade_top(3'd5)) begin
			target = 3'd5;
		end else begin
			target = 3'd0;
		end
		range_up   = {1'b0, range_q} + 4'd1;
		hz_x5      = {hz_q, 2'b00} + (HZ_W+3)'(hz_q);
		// A switch of one decade is immediate only above 1.6 times the guard top.
		fast       = ({1'b0, target} > range_up) || (({1'b0, target} == range_up)
			&& (hz_x5 > ((HZ_W+3)'(guard_max(range_q)) << 3)));
		if (cand_q == target) begin
			next_votes = (votes_q < 2'd3) ? votes_q + 2'd1 : votes_q;
		end else begin
			next_votes = 2'd1;
		end
		do_switch  = fast || (next_votes >= 2'd2);
		in_band    = (hz_q > guard_min(sel_q)) && (hz_q <= guard_max(sel_q));
		switching  = !job_q.invalid && (sel_q == RANGE_AUTO) && (target != 3'd0)
			&& (target != range_q) && do_switch;
		// The sample is stored whenever a valid job goes on to averaging.
		store      = !job_q.invalid && ((sel_q == RANGE_AUTO) ? ((target != 3'd0)
			&& ((target == range_q) || !do_switch)) : in_band);
		new_fill   = (fill_q == FILL_W'(HIST_DEPTH)) ? fill_q : fill_q + 1'b1;
		if (hz_q < HZ_W'(100 << FRAC_BITS)) begin
			window = FILL_W'(8);
		end else if (hz_q < HZ_W'(1000 << FRAC_BITS)) begin
			window = FILL_W'(6);
		end else begin
			window = FILL_W'(4);
		end
		prev_idx = idx_q - 1'b1;
		out_free = !out_valid_q || pop;
		cfg_sel  = (cfg_data > 3'd5) ? RANGE_AUTO : cfg_data;
	end

	always_comb begin
		take        = (state_q == S_IDLE) && avail;
		div_req     = '0;
		div_req.den = job_q.period;
		unique case (state_q)
			S_IDLE: begin
				div_req.start = avail && !head.invalid;
				div_req.num   = DIV_W'(head.hz_num);
				div_req.den   = head.period;
			end
			S_DHZ: begin
				div_req.start = div_rsp.done;
				div_req.num   = DIV_W'(job_q.duty_num);
			end
			S_SUM: begin
				div_req.start = (left_q == '0);
				div_req.num   = DIV_W'(sum_hz_q);
				div_req.den   = 32'(n_q);
			end
			S_AVGH: begin
				div_req.start = div_rsp.done;
				div_req.num   = DIV_W'(sum_duty_q);
				div_req.den   = 32'(n_q);
			end
			S_DDUTY, S_DECIDE, S_AVGD, S_EMIT: begin
				div_req.start = 1'b0;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= head;
		end
		if ((state_q == S_DHZ) && div_rsp.done) begin
			hz_q <= div_rsp.quo[HZ_W-1:0];
		end
		if ((state_q == S_DDUTY) && div_rsp.done) begin
			duty_q <= div_rsp.quo[14:0];
		end
		if ((state_q == S_DECIDE) && store) begin
			hist_hz_q[wp_q]   <= hz_q[25:0];
			hist_duty_q[wp_q] <= duty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			inv_cnt_q   <= 8'd0;
			range_q     <= RANGE_RESET;
			cand_q      <= NO_CAND;
			votes_q     <= 2'd0;
			ovf_q       <= 1'b0;
			sel_q       <= RANGE_AUTO;
			started_q   <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			left_q      <= '0;
			sum_hz_q    <= '0;
			sum_duty_q  <= '0;
			status_q    <= ST_OK;
			changed_q   <= 1'b0;
			avg_hz_q    <= '0;
			avg_duty_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SELECT: begin
						sel_q     <= cfg_sel;
						ovf_q     <= 1'b0;
						votes_q   <= 2'd0;
						cand_q    <= NO_CAND;
						wp_q      <= '0;
						fill_q    <= '0;
						inv_cnt_q <= 8'd0;
						if (cfg_sel != RANGE_AUTO) begin
							range_q <= cfg_sel;
						end else if (range_q < 3'd1 || range_q > 3'd5) begin
							range_q <= RANGE_RESET;
						end
					end
					REG_STARTED: begin
						started_q <= cfg_data[0];
					end
					default: begin
						started_q <= started_q;
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (avail) begin
						state_q <= head.invalid ? S_DECIDE : S_DHZ;
					end
				end
				S_DHZ: begin
					if (div_rsp.done) begin
						state_q <= S_DDUTY;
					end
				end
				S_DDUTY: begin
					if (div_rsp.done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					changed_q  <= switching;
					avg_hz_q   <= '0;
					avg_duty_q <= '0;
					sum_hz_q   <= '0;
					sum_duty_q <= '0;
					if (job_q.invalid) begin
						if (hw_fail) begin
							inv_cnt_q <= inc_cnt;
							status_q  <= ST_HW_FAIL;
							state_q   <= S_EMIT;
						end else begin
							inv_cnt_q <= eff_cnt;
							if (stale) begin
								wp_q   <= '0;
								fill_q <= '0;
							end
							if (use_hist) begin
								// The whole history is averaged.
								status_q <= ST_OK;
								n_q      <= fill_q;
								left_q   <= fill_q;
								idx_q    <= wp_q;
								state_q  <= S_SUM;
							end else begin
								status_q <= ST_NO_SIG;
								state_q  <= S_EMIT;
							end
						end
					end else begin
						inv_cnt_q <= 8'd0;
						if (store) begin
							status_q <= ST_OK;
							wp_q     <= wp_q + 1'b1;
							fill_q   <= new_fill;
							idx_q    <= wp_q + 1'b1;
							n_q      <= (window < new_fill) ? window : new_fill;
							left_q   <= (window < new_fill) ? window : new_fill;
							state_q  <= S_SUM;
						end else begin
							status_q <= switching ? ST_NO_SIG : ST_OVER;
							state_q  <= S_EMIT;
							// An auto overrange keeps the history; the other cases drop it.
							if (switching || (sel_q != RANGE_AUTO)) begin
								wp_q   <= '0;
								fill_q <= '0;
							end
						end
						if (sel_q == RANGE_AUTO) begin
							if (target == 3'd0) begin
								votes_q <= 2'd0;
								cand_q  <= NO_CAND;
								ovf_q   <= 1'b1;
							end else if (target == range_q) begin
								votes_q <= 2'd0;
								cand_q  <= NO_CAND;
								ovf_q   <= 1'b0;
							end else if (do_switch) begin
								range_q <= target;
								votes_q <= 2'd0;
								cand_q  <= NO_CAND;
								ovf_q   <= 1'b0;
							end else begin
								cand_q  <= target;
								votes_q <= next_votes;
								ovf_q   <= 1'b0;
							end
						end else begin
							ovf_q <= !in_band;
						end
					end
				end
				S_SUM: begin
					if (left_q != '0) begin
						sum_hz_q   <= sum_hz_q + 29'(hist_hz_q[prev_idx]);
						sum_duty_q <= sum_duty_q + 18'(hist_duty_q[prev_idx]);
						idx_q      <= prev_idx;
						left_q     <= left_q - 1'b1;
					end else begin
						state_q <= S_AVGH;
					end
				end
				S_AVGH: begin
					if (div_rsp.done) begin
						avg_hz_q <= div_rsp.quo[25:0];
						state_q  <= S_AVGD;
					end
				end
				S_AVGD: begin
					if (div_rsp.done) begin
						avg_duty_q <= div_rsp.quo[14:0];
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.status         <= status_q;
						out_q.avg_hz         <= avg_hz_q;
						out_q.avg_duty       <= avg_duty_q;
						out_q.active_range   <= range_q;
						out_q.overrange      <= ovf_q;
						out_q.range_changed  <= changed_q;
						out_q.invalid_streak <= inv_cnt_q;
						out_q.history_level  <= fill_q;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

/* hdl/freq_duty_autorange_meter_core.sv */
// Frequency and duty meter with decade auto-ranging, top level.
// An invalid capture answered without history needs no division; one averaged from
// n = 1..8 entries needs two divisions, and a stored valid one needs four, all on one
// bit-serial divider, with one history read per averaged entry.
// One capture at a time is in the back end; two more wait in the front.
// Reset (arst_n low) clears control state at once; no clearing pass is needed.
module freq_duty_autorange_meter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  fdm_pkg::capture_t capture,
	output logic              empty,
	input  logic              pop,
	output fdm_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [2:0]        cfg_data
);
	import fdm_pkg::*;

	logic     take;
	logic     avail;
	job_t     head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	fdm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.capture (capture),
		.take    (take),
		.avail   (avail),
		.head    (head)
	);

	fdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.avail     (avail),
		.head      (head),
		.take      (take),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

/* tb/tb.sv */
// Testbench for freq_duty_autorange_meter_core: drives timer captures, predicts
// each reading with an in-bench model of the meter and checks every result word.
// Depends on fdm_pkg for the payload structs and the status and register codes.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fdm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	capture_t capture = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SELECT;
	logic [2:0] cfg_data = '0;

	freq_duty_autorange_meter_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .capture(capture),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	capture_t capture_queue[$];
	result_t expected_readings[$];
	int errors = 0;

	// Model state of the meter.
	logic [31:0] hz_ring[8];
	logic [31:0] duty_ring[8];
	int unsigned wr_ptr, fill, bad_count, cur_range, cand, votes, over_flag;
	int unsigned sel_reg, started_reg;

	function automatic longint unsigned scaled(input longint unsigned hz);
		return hz << 8;
	endfunction

	function automatic longint unsigned top_of(input int unsigned r);
		case (r)
			1: return scaled(20);
			2: return scaled(200);
			3: return scaled(2000);
			4: return scaled(20000);
			5: return scaled(200000);
			default: return 0;
		endcase
	endfunction

	function automatic longint unsigned band_lo(input int unsigned r);
		case (r)
			2: return scaled(18);
			3: return scaled(180);
			4: return scaled(1800);
			5: return scaled(18000);
			default: return 0;
		endcase
	endfunction

	function automatic longint unsigned band_hi(input int unsigned r);
		return top_of(r) + top_of(r) / 10;
	endfunction

	function automatic int unsigned bad_limit(input int unsigned r);
		case (r)
			1: return 8;
			2: return 7;
			3: return 5;
			4: return 4;
			5: return 3;
			default: return 5;
		endcase
	endfunction

	function void wipe_history();
		wr_ptr = 0;
		fill = 0;
		bad_count = 0;
	endfunction

	function void mean_of(input int unsigned window, output longint unsigned ahz,
			output longint unsigned aduty);
		int unsigned n, idx;
		longint unsigned hs, ds;
		n = window < fill ? window : fill;
		idx = wr_ptr;
		hs = 0;
		ds = 0;
		ahz = 0;
		aduty = 0;
		if (n != 0) begin
			for (int i = 0; i < n; i++) begin
				idx = (idx + 7) % 8;
				hs += hz_ring[idx];
				ds += duty_ring[idx];
			end
			ahz = hs / n;
			aduty = ds / n;
		end
	endfunction

	// Returns 1 when auto ranging moves to a new decade.
	function bit track_range(input longint unsigned hz);
		int unsigned tgt;
		bit quick;
		tgt = 0;
		if (hz != 0)
			for (int r = 5; r >= 1; r--)
				if (hz <= top_of(r))
					tgt = r;
		if (tgt == 0) begin
			votes = 0;
			cand = NO_CAND;
			over_flag = 1;
			return 0;
		end
		over_flag = 0;
		if (tgt == cur_range) begin
			votes = 0;
			cand = NO_CAND;
			return 0;
		end
		quick = 0;
		if (cur_range >= 1 && cur_range <= 5 && tgt > cur_range)
			quick = (tgt > cur_range + 1) || (hz * 5 > band_hi(cur_range) * 8);
		if (!quick) begin
			if (cand == tgt) begin
				if (votes < 3)
					votes++;
			end else begin
				cand = tgt;
				votes = 1;
			end
			if (votes < 2)
				return 0;
		end
		cur_range = tgt;
		votes = 0;
		cand = NO_CAND;
		wipe_history();
		return 1;
	endfunction

	function void apply_register(input logic idx, input logic [2:0] val);
		int unsigned s;
		if (idx == REG_SELECT) begin
			s = val > 5 ? 0 : val;
			sel_reg = s;
			over_flag = 0;
			votes = 0;
			cand = NO_CAND;
			if (s != 0)
				cur_range = s;
			wipe_history();
		end else begin
			started_reg = val[0];
		end
	endfunction

	function void compute_reading(input capture_t c);
		result_t r;
		longint unsigned hz, duty, ahz, aduty;
		bit keep;
		int unsigned win;
		r = '0;
		ahz = 0;
		aduty = 0;
		if (!c.capture_valid || c.period_cnt == 0 || c.clock_hz == 0 ||
				c.high_cnt > c.period_cnt) begin
			if (bad_count < 255)
				bad_count++;
			if (!started_reg && fill == 0) begin
				r.status = ST_HW_FAIL;
			end else begin
				if (cur_range >= 4 && bad_count >= 2)
					wipe_history();
				if (bad_count < bad_limit(cur_range) && fill > 0)
					mean_of(8, ahz, aduty);
				else
					r.status = ST_NO_SIG;
			end
		end else begin
			hz = (longint'(c.clock_hz) << 8) / c.period_cnt;
			duty = ((longint'(c.high_cnt) * 100) << 8) / c.period_cnt;
			keep = 1;
			bad_count = 0;
			if (sel_reg == 0) begin
				if (track_range(hz)) begin
					r.status = ST_NO_SIG;
					r.range_changed = 1'b1;
					keep = 0;
				end else if (over_flag) begin
					r.status = ST_OVER;
					keep = 0;
				end
			end else if (!(hz > band_lo(sel_reg) && hz <= band_hi(sel_reg))) begin
				over_flag = 1;
				wipe_history();
				r.status = ST_OVER;
				keep = 0;
			end else begin
				over_flag = 0;
			end
			if (keep) begin
				win = hz < scaled(100) ? 8 : (hz < scaled(1000) ? 6 : 4);
				hz_ring[wr_ptr] = hz[31:0];
				duty_ring[wr_ptr] = duty[31:0];
				wr_ptr = (wr_ptr + 1) % 8;
				if (fill < 8)
					fill++;
				mean_of(win, ahz, aduty);
			end
		end
		r.avg_hz = ahz[25:0];
		r.avg_duty = aduty[14:0];
		r.active_range = cur_range[2:0];
		r.overrange = over_flag[0];
		r.invalid_streak = bad_count[7:0];
		r.history_level = fill[3:0];
		expected_readings.push_back(r);
	endfunction

	// Idle lengths: mostly short, now and then long, and bursts with none at all.
	function automatic int gap_len(input bit busy_mode);
		int p;
		p = $urandom_range(99);
		if (busy_mode || p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(1, 6);
		return $urandom_range(20, 400);
	endfunction

	int tx_gap = 0, rx_gap = 0;
	bit tx_busy = 0, rx_busy = 0;
	int accepted_words = 0;

	always @(posedge clk) begin
		capture_t nxt;
		bit go;
		if (push && !full) begin
			compute_reading(capture_queue.pop_front());
			accepted_words++;
			tx_gap = gap_len(tx_busy);
			if (accepted_words % 97 == 0)
				tx_busy = $urandom_range(1);
		end
		go = 0;
		nxt = capture;
		if (tx_gap > 0)
			tx_gap--;
		else if (capture_queue.size() != 0) begin
			go = 1;
			nxt = capture_queue[0];
		end
		push <= go;
		capture <= nxt;
	end

	always @(posedge clk) begin
		result_t e;
		if (pop && !empty) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected result word: %p", result);
				errors++;
			end else begin
				e = expected_readings.pop_front();
				if (result.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, result.status);
					errors++;
				end
				if (result.avg_hz !== e.avg_hz) begin
					$error("avg_hz expected %0d got %0d", e.avg_hz, result.avg_hz);
					errors++;
				end
				if (result.avg_duty !== e.avg_duty) begin
					$error("avg_duty expected %0d got %0d", e.avg_duty, result.avg_duty);
					errors++;
				end
				if (result.active_range !== e.active_range) begin
					$error("active_range expected %0d got %0d", e.active_range,
						result.active_range);
					errors++;
				end
				if (result.overrange !== e.overrange) begin
					$error("overrange expected %0d got %0d", e.overrange, result.overrange);
					errors++;
				end
				if (result.range_changed !== e.range_changed) begin
					$error("range_changed expected %0d got %0d", e.range_changed,
						result.range_changed);
					errors++;
				end
				if (result.invalid_streak !== e.invalid_streak) begin
					$error("invalid_streak expected %0d got %0d", e.invalid_streak,
						result.invalid_streak);
					errors++;
				end
				if (result.history_level !== e.history_level) begin
					$error("history_level expected %0d got %0d", e.history_level,
						result.history_level);
					errors++;
				end
			end
			rx_gap = gap_len(rx_busy);
			if ($urandom_range(60) == 0)
				rx_busy = $urandom_range(1);
		end
		if (rx_gap > 0) begin
			rx_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic capture_t make_cap(input bit v, input logic [31:0] per,
			input logic [31:0] hi, input logic [31:0] ck);
		capture_t c;
		c.capture_valid = v;
		c.period_cnt = per;
		c.high_cnt = hi;
		c.clock_hz = ck;
		return c;
	endfunction

	// A well-formed capture of a signal near freq Hz.
	function automatic capture_t tone(input int unsigned freq);
		logic [31:0] ck, per;
		int unsigned f;
		case ($urandom_range(3))
			0: ck = 32'd1_000_000;
			1: ck = 32'd16_000_000;
			2: ck = 32'd72_000_000;
			default: ck = $urandom_range(32'd500_000, 32'd200_000_000);
		endcase
		f = 32'(longint'(freq) * $urandom_range(88, 112) / 100);
		if (f == 0)
			f = 1;
		per = ck / f;
		if (per == 0)
			per = 1;
		return make_cap(1'b1, per, $urandom_range(per, 0), ck);
	endfunction

	function automatic capture_t broken();
		logic [31:0] p;
		p = $urandom;
		case ($urandom_range(3))
			0: return make_cap(1'b0, $urandom, $urandom, $urandom);
			1: return make_cap(1'b1, 32'd0, $urandom, $urandom);
			2: return make_cap(1'b1, p | 32'd1, $urandom, 32'd0);
			default: return make_cap(1'b1, p >> 1, (p >> 1) + $urandom_range(1, 1000),
				$urandom);
		endcase
	endfunction

	function automatic int unsigned decade_freq(input int unsigned r);
		case (r)
			1: return $urandom_range(2, 21);
			2: return $urandom_range(19, 219);
			3: return $urandom_range(181, 2199);
			4: return $urandom_range(1801, 21999);
			default: return $urandom_range(18001, 219999);
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [2:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_register(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (capture_queue.size() == 0 && expected_readings.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned sel, input int count);
		int unsigned base;
		int n, burst;
		base = decade_freq($urandom_range(1, 5));
		n = 0;
		while (n < count) begin
			if ($urandom_range(19) == 0)
				base = (sel >= 1 && sel <= 5 && $urandom_range(3) != 0) ?
					decade_freq(sel) : decade_freq($urandom_range(1, 5));
			case ($urandom_range(19))
				0, 1: begin
					burst = $urandom_range(1, 10);
					repeat (burst) capture_queue.push_back(broken());
					n += burst;
				end
				2: begin
					capture_queue.push_back(make_cap($urandom, $urandom, $urandom, $urandom));
					n++;
				end
				3: begin
					capture_queue.push_back(tone($urandom_range(250_000, 3_000_000)));
					n++;
				end
				default: begin
					capture_queue.push_back(tone(base));
					n++;
				end
			endcase
		end
	endtask

	initial begin
		int unsigned sels[10] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 0};
		cur_range = RANGE_RESET;
		cand = NO_CAND;
		votes = 0;
		over_flag = 0;
		sel_reg = 0;
		started_reg = 0;
		wipe_history();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Front end not started: invalid captures with no history are hardware fail.
		capture_queue.push_back(make_cap(1'b0, 32'd1000, 32'd10, 32'd1_000_000));
		capture_queue.push_back(make_cap(1'b1, 32'd0, 32'd0, 32'd1_000_000));
		capture_queue.push_back(make_cap(1'b1, 32'd1000, 32'd1001, 32'd1_000_000));
		capture_queue.push_back(make_cap(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0));
		// Zero frequency and a huge one are both overrange in auto mode.
		capture_queue.push_back(make_cap(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
		capture_queue.push_back(make_cap(1'b1, 32'd1, 32'd1, 32'hFFFF_FFFF));
		drain();

		write_reg(REG_STARTED, 3'd1);
		// Settle at 1 kHz, then vote down to 200 Hz, then jump straight up.
		repeat (3) capture_queue.push_back(make_cap(1'b1, 32'd1000, 32'd250, 32'd1_000_000));
		repeat (2) capture_queue.push_back(make_cap(1'b1, 32'd10000, 32'd10000, 32'd1_000_000));
		capture_queue.push_back(make_cap(1'b1, 32'd100, 32'd0, 32'd16_000_000));
		capture_queue.push_back(make_cap(1'b1, 32'd100, 32'd30, 32'd16_000_000));
		// Stale history in a high range on repeated invalid captures.
		repeat (3) capture_queue.push_back(make_cap(1'b0, 32'd0, 32'd0, 32'd0));
		drain();

		// Manual 20 Hz range: zero frequency and above-band are out of band.
		write_reg(REG_SELECT, 3'd1);
		capture_queue.push_back(make_cap(1'b1, 32'd100_000, 32'd5, 32'd1_000_000));
		capture_queue.push_back(make_cap(1'b1, 32'hFFFF_FFFF, 32'd7, 32'd1000));
		capture_queue.push_back(make_cap(1'b1, 32'd1000, 32'd500, 32'd1_000_000));
		repeat (9) capture_queue.push_back(make_cap(1'b0, 32'd5, 32'd1, 32'd9));
		drain();

		foreach (sels[i]) begin
			write_reg(REG_SELECT, 3'(sels[i]));
			write_reg(REG_STARTED, (i == 0 || i == 6) ? 3'd0 : 3'($urandom_range(1)));
			random_phase(sels[i], 152);
			drain();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#80ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule

/* sim.f */
hdl/fdm_pkg.sv
hdl/fdm_front.sv
hdl/fdm_div.sv
hdl/fdm_back.sv
hdl/freq_duty_autorange_meter_core.sv
tb/tb.sv
